### src/hex_frame_xor_receive_check_unit_defines.svh
// ----------------------------------------------------------------------------
// hex frame xor receive check: assertion macros
// shared concurrent assertion forms used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef HEX_FRAME_XOR_RECEIVE_CHECK_UNIT_DEFINES_SVH
`define HEX_FRAME_XOR_RECEIVE_CHECK_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define HFXRC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hfxrc same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define HFXRC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hfxrc next-cycle check failed");

`endif

### src/hfxrc_pkg.sv
// ----------------------------------------------------------------------------
// hfxrc_pkg
// character codes, result type and decode helpers for the frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package hfxrc_pkg;

    localparam logic [7:0] OPEN_CHAR  = 8'h5B;  // '['
    localparam logic [7:0] CLOSE_CHAR = 8'h5D;  // ']'

    // position at which the frame, with its ']', reaches the minimum length
    localparam int unsigned MIN_CLOSE_POS = 3;

    typedef struct packed {
        logic frame_good;
        logic frame_closed;
    } hfxrc_result_t;

    // sign extension of a character into the 9-bit checksum domain
    function automatic logic [8:0] sext9(input logic [7:0] c);
        sext9 = {c[7], c};
    endfunction

    // uppercase hex digit, anything else reads as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = c - 8'h37;
        end
        hex_nibble = d[3:0];
    endfunction

endpackage

`default_nettype wire

### src/hex_frame_xor_receive_check_unit.sv
// ----------------------------------------------------------------------------
// hex frame xor receive check unit
// receive-side checker for '['...']' framed ascii-hex messages with an xor
// checksum, one flag pair per received character
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                         transfer when
//  s_        in         s_rx_char[7:0]                  s_valid & s_ready
//  m_        out        m_frame_good, m_frame_closed    m_valid & m_ready
//
//  one character per cycle sustained while s_ready is high; its result, set by the
//  frame state update, is registered into the result or, on a stall, the skid register
//  a two-entry output (result register plus skid register) lets a character
//  be taken while one result waits; s_ready drops only when both are full
//  aresetn (synchronous, active low) clears the frame state and both entries
//
`default_nettype none

`include "hex_frame_xor_receive_check_unit_defines.svh"

module hex_frame_xor_receive_check_unit #(
    parameter int unsigned FRAME_LIMIT = 256
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_rx_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_frame_good,
    output logic            m_frame_closed
);

    import hfxrc_pkg::*;

    // position count holds 0 .. FRAME_LIMIT
    localparam int unsigned CNT_W = $clog2(FRAME_LIMIT + 1);

    // frame state
    logic [CNT_W-1:0] position_count_reg, position_count_next;
    logic             frame_open_reg, frame_open_next;
    logic [7:0]       older_char_reg, older_char_next;
    logic [7:0]       newer_char_reg, newer_char_next;
    logic [8:0]       running_xor_reg, running_xor_next;

    // output stage: result register and skid register
    logic          out_valid_reg, out_valid_next;
    hfxrc_result_t out_data_reg, out_data_next;
    logic          skid_valid_reg, skid_valid_next;
    hfxrc_result_t skid_data_reg, skid_data_next;

    logic             s_accept;
    logic             m_accept;
    logic             overflow;
    logic [CNT_W-1:0] count_eff;
    logic             open_eff;
    logic [8:0]       check_value;
    logic [8:0]       hex_value;
    hfxrc_result_t    new_result;

    assign s_ready  = !skid_valid_reg;
    assign s_accept = s_valid && s_ready;
    assign m_accept = out_valid_reg && m_ready;

    // overflow drops the open frame before the character is handled
    assign overflow  = position_count_reg >= CNT_W'(FRAME_LIMIT);
    assign count_eff = overflow ? '0 : position_count_reg;
    assign open_eff  = overflow ? 1'b0 : frame_open_reg;

    // with no payload between '[' and the checksum only position 1 is compared
    assign check_value = (count_eff == CNT_W'(MIN_CLOSE_POS)) ? sext9(older_char_reg)
                                                               : running_xor_reg;
    assign hex_value   = {1'b0, hex_nibble(older_char_reg), hex_nibble(newer_char_reg)};

    // per-character frame update
    always_comb begin
        position_count_next = position_count_reg;
        frame_open_next     = frame_open_reg;
        older_char_next     = older_char_reg;
        newer_char_next     = newer_char_reg;
        running_xor_next    = running_xor_reg;
        new_result          = '0;
        if (s_accept) begin
            position_count_next = count_eff;
            frame_open_next     = open_eff;
            if (s_rx_char == OPEN_CHAR) begin
                // restart: position 0 holds the '['
                position_count_next = CNT_W'(1);
                frame_open_next     = 1'b1;
                older_char_next     = '0;
                newer_char_next     = '0;
                running_xor_next    = '0;
            end else if (s_rx_char == CLOSE_CHAR) begin
                // a stray close changes nothing beyond the overflow drop
                if (open_eff) begin
                    new_result.frame_closed = 1'b1;
                    new_result.frame_good   = (count_eff >= CNT_W'(MIN_CLOSE_POS))
                                              && (hex_value == check_value);
                    position_count_next     = '0;
                    frame_open_next         = 1'b0;
                    older_char_next         = '0;
                    newer_char_next         = '0;
                    running_xor_next        = '0;
                end
            end else begin
                // the character leaving the two-character delay joins the xor
                if (count_eff >= CNT_W'(MIN_CLOSE_POS)) begin
                    running_xor_next = running_xor_reg ^ sext9(older_char_reg);
                end
                older_char_next     = newer_char_reg;
                newer_char_next     = s_rx_char;
                position_count_next = count_eff + CNT_W'(1);
            end
        end
    end

    // output stage steering
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || m_accept) begin
            // result register free this cycle: skid first, else the new result
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = s_accept;
                out_data_next  = new_result;
            end
        end else if (s_accept) begin
            // result register held by a stalled sink
            skid_valid_next = 1'b1;
            skid_data_next  = new_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_count_reg <= '0;
            frame_open_reg     <= 1'b0;
            older_char_reg     <= '0;
            newer_char_reg     <= '0;
            running_xor_reg    <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            position_count_reg <= position_count_next;
            frame_open_reg     <= frame_open_next;
            older_char_reg     <= older_char_next;
            newer_char_reg     <= newer_char_next;
            running_xor_reg    <= running_xor_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_frame_good   = out_data_reg.frame_good;
    assign m_frame_closed = out_data_reg.frame_closed;

    // skid entry is only ever filled behind a held result
    `HFXRC_ASSERT_NOW(a_skid_behind_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    // a good frame is always a closed frame
    `HFXRC_ASSERT_NOW(a_good_implies_closed, aclk, aresetn, out_valid_reg,
                      !out_data_reg.frame_good || out_data_reg.frame_closed)
    // a '[' transfer opens a fresh frame at position 1
    `HFXRC_ASSERT_NEXT(a_open_restarts, aclk, aresetn,
                       s_accept && (s_rx_char == OPEN_CHAR),
                       frame_open_reg && (position_count_reg == CNT_W'(1))
                       && (running_xor_reg == 9'd0))
    // a ']' transfer always leaves the frame closed
    `HFXRC_ASSERT_NEXT(a_close_shuts, aclk, aresetn,
                       s_accept && (s_rx_char == CLOSE_CHAR), !frame_open_reg)

endmodule

`default_nettype wire
